FILE: sv/bce_pkg.sv
package bce_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int PASSES_DEF    = 3;

  // Frame dimension registers and row counters
  localparam int DIM_W = 12;
  localparam int ROW_W = DIM_W + 1;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [DIM_W-1:0]     DIM_RESET        = 12'd2048;

  typedef struct packed {
    logic pixel_in;
    logic flush;
  } in_item_t;

  typedef struct packed {
    logic pixel_out;
    logic frame_last;
  } out_item_t;

  // Token moving through the erosion stages, one per taken item
  typedef struct packed {
    logic vld;   // slot holds a token
    logic sof;   // first token of a frame
    logic pv;    // token carries a pixel for the next stage
    logic pix;   // pixel value
    logic eof;   // pixel is the last one of the frame
  } tok_t;

endpackage

FILE: sv/bce_feed.sv
module bce_feed #(
  parameter int MAX_WIDTH = bce_pkg::MAX_WIDTH_DEF,
  parameter int PASSES    = bce_pkg::PASSES_DEF,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  bce_pkg::in_item_t                   in_data,
  input  logic                                cfg_we,
  input  logic [bce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bce_pkg::DIM_W-1:0]           cfg_data,
  output bce_pkg::tok_t                       tok_o,
  output logic [CW-1:0]                       wl_o,
  output logic [bce_pkg::DIM_W-1:0]           fh_o,
  output logic                                take_o
);
  import bce_pkg::*;

  localparam int TW = $clog2(MAX_WIDTH + 1);
  localparam int PW = (PASSES > 1) ? $clog2(PASSES) : 1;

  logic [DIM_W-1:0] cfg_w_r, cfg_h_r;
  logic             active_r, active_nxt;
  logic [CW-1:0]    wl_r, x_r, x_nxt;
  logic [DIM_W-1:0] fh_r, y_r, y_nxt;
  logic [TW-1:0]    tx_r, tx_nxt;
  logic [PW-1:0]    tp_r, tp_nxt;
  tok_t             tok_r, tok_nxt;
  logic [CW-1:0]    wl_o_r;
  logic [DIM_W-1:0] fh_o_r;

  logic [CW-1:0]    wl_cfg, wl_e, x_e;
  logic [DIM_W-1:0] fh_cfg, fh_e, y_e;
  logic [TW-1:0]    tx_e;
  logic [PW-1:0]    tp_e;
  logic             acc, start, pix_ph, take, tail_end, tx_wrap;

  // Frame size as latched at frame start: zero becomes one, width saturates
  always_comb begin
    if (cfg_w_r == '0) begin
      wl_cfg = '0;
    end else if (32'(cfg_w_r) > 32'(MAX_WIDTH)) begin
      wl_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      wl_cfg = CW'(cfg_w_r - 12'd1);
    end
    fh_cfg = (cfg_h_r == '0) ? 12'd1 : cfg_h_r;
  end

  // Decide what the item does: start a frame, feed a pixel, drain, or drop
  always_comb begin
    acc      = in_valid && !in_stall;
    start    = !active_r;
    wl_e     = start ? wl_cfg : wl_r;
    fh_e     = start ? fh_cfg : fh_r;
    x_e      = start ? '0 : x_r;
    y_e      = start ? '0 : y_r;
    tx_e     = start ? '0 : tx_r;
    tp_e     = start ? '0 : tp_r;
    pix_ph   = y_e < fh_e;
    take     = acc && (!pix_ph || !in_data.flush);
    tx_wrap  = tx_e == (TW'(wl_e) + TW'(1));
    tail_end = !pix_ph && tx_wrap && (tp_e == PW'(PASSES - 1));
  end

  // Advance the frame counters
  always_comb begin
    active_nxt = active_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    tx_nxt     = tx_r;
    tp_nxt     = tp_r;
    if (take) begin
      active_nxt = !tail_end;
      x_nxt      = x_e;
      y_nxt      = y_e;
      tx_nxt     = tx_e;
      tp_nxt     = tp_e;
      if (pix_ph) begin
        if (x_e == wl_e) begin
          x_nxt = '0;
          y_nxt = y_e + 12'd1;
        end else begin
          x_nxt = x_e + CW'(1);
        end
      end else if (tx_wrap) begin
        tx_nxt = '0;
        tp_nxt = tp_e + PW'(1);
      end else begin
        tx_nxt = tx_e + TW'(1);
      end
    end
  end

  // Build the token for the first stage
  always_comb begin
    tok_nxt.vld = take;
    tok_nxt.sof = take && start;
    tok_nxt.pv  = pix_ph;
    tok_nxt.pix = in_data.pixel_in;
    tok_nxt.eof = 1'b0;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r  <= DIM_RESET;
      cfg_h_r  <= DIM_RESET;
      active_r <= 1'b0;
      x_r      <= '0;
      y_r      <= '0;
      tx_r     <= '0;
      tp_r     <= '0;
      tok_r    <= '0;
    end else begin
      if (cfg_we && (cfg_index == CFG_IMAGE_WIDTH)) begin
        cfg_w_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == CFG_IMAGE_HEIGHT)) begin
        cfg_h_r <= cfg_data;
      end
      active_r <= active_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      tx_r     <= tx_nxt;
      tp_r     <= tp_nxt;
      tok_r    <= tok_nxt;
    end
  end

  // Frame size travels with the token
  always_ff @(posedge clk) begin
    if (take) begin
      wl_r <= wl_e;
      fh_r <= fh_e;
    end
    wl_o_r <= wl_e;
    fh_o_r <= fh_e;
  end

  assign tok_o  = tok_r;
  assign wl_o   = wl_o_r;
  assign fh_o   = fh_o_r;
  assign take_o = take;

endmodule

FILE: sv/bce_stage.sv
module bce_stage #(
  parameter int MAX_WIDTH = bce_pkg::MAX_WIDTH_DEF,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bce_pkg::tok_t             tin,
  input  logic [CW-1:0]             tin_wl,
  input  logic [bce_pkg::DIM_W-1:0] tin_fh,
  output bce_pkg::tok_t             tout,
  output logic [CW-1:0]             tout_wl,
  output logic [bce_pkg::DIM_W-1:0] tout_fh
);
  import bce_pkg::*;

  // Line buffer: bit 0 holds row y-1, bit 1 holds row y-2, per column
  logic [1:0] lb_mem [MAX_WIDTH];

  // Position of the next input pixel of this stage
  logic [CW-1:0]    x_r, x_nxt;
  logic [ROW_W-1:0] y_r, y_nxt;
  logic             done_r, done_nxt;

  // Read stage registers
  tok_t             a_tok_r;
  logic [CW-1:0]    a_wl_r, a_x_r;
  logic [DIM_W-1:0] a_fh_r;
  logic             a_tick_r, a_emit_r, a_last_r, a_xz_r, a_x2_r, a_w2_r;
  logic             a_top_r, a_inrow_r;
  logic [1:0]       rd_r, fwd_d_r;
  logic             fwd_r;

  // Column results and output registers
  logic             c1_r, c2_r;
  tok_t             tout_r;
  logic [CW-1:0]    tout_wl_r;
  logic [DIM_W-1:0] tout_fh_r;

  logic             sof_v, done_e, tick, wrap, emit, last_pos;
  logic [CW-1:0]    x_e;
  logic [ROW_W-1:0] y_e, fh13;
  logic [1:0]       d, wdata;
  logic             c0, res;
  tok_t             tout_nxt;

  // Decide whether this stage moves on the token, and where it stands
  always_comb begin
    sof_v    = tin.vld && tin.sof;
    x_e      = sof_v ? '0 : x_r;
    y_e      = sof_v ? '0 : y_r;
    done_e   = sof_v ? 1'b0 : done_r;
    fh13     = {1'b0, tin_fh};
    tick     = tin.vld && !done_e && (tin.pv || (y_e >= fh13));
    wrap     = x_e == tin_wl;
    last_pos = (x_e == '0) && (y_e == fh13 + ROW_W'(1));
    emit     = tick && (((y_e != '0) && (x_e != '0)) ||
                        ((y_e > ROW_W'(1)) && (x_e == '0)));
    x_nxt    = x_r;
    y_nxt    = y_r;
    done_nxt = done_r;
    if (tin.vld) begin
      x_nxt    = x_e;
      y_nxt    = y_e;
      done_nxt = done_e || (tick && last_pos);
      if (tick) begin
        if (wrap) begin
          x_nxt = '0;
          y_nxt = y_e + ROW_W'(1);
        end else begin
          x_nxt = x_e + CW'(1);
        end
      end
    end
  end

  // Column AND over rows y-2..y, window AND over three columns
  always_comb begin
    d     = fwd_r ? fwd_d_r : rd_r;
    wdata = {d[0], a_tok_r.pix};
    c0    = (a_tok_r.pix | !a_inrow_r) & d[0] & (d[1] | !a_top_r);
    if (a_xz_r) begin
      res = c1_r & (c2_r | !a_w2_r);
    end else begin
      res = c0 & c1_r & (c2_r | !a_x2_r);
    end
    tout_nxt.vld = a_tok_r.vld;
    tout_nxt.sof = a_tok_r.sof;
    tout_nxt.pv  = a_emit_r;
    tout_nxt.pix = res;
    tout_nxt.eof = a_emit_r && a_last_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '0;
      done_r   <= 1'b0;
      a_tok_r  <= '0;
      a_tick_r <= 1'b0;
      a_emit_r <= 1'b0;
      tout_r   <= '0;
    end else begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      done_r   <= done_nxt;
      a_tok_r  <= tin;
      a_tick_r <= tick;
      a_emit_r <= emit;
      tout_r   <= tout_nxt;
    end
  end

  // Line buffer: read now, write back in the next cycle; forward on a hit
  always_ff @(posedge clk) begin
    if (a_tick_r) begin
      lb_mem[a_x_r] <= wdata;
    end
    rd_r    <= lb_mem[x_e];
    fwd_r   <= a_tick_r && (a_x_r == x_e);
    fwd_d_r <= wdata;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_wl_r    <= tin_wl;
    a_fh_r    <= tin_fh;
    a_x_r     <= x_e;
    a_last_r  <= last_pos;
    a_xz_r    <= x_e == '0;
    a_x2_r    <= x_e > CW'(1);
    a_w2_r    <= tin_wl != '0;
    a_top_r   <= y_e > ROW_W'(1);
    a_inrow_r <= y_e < fh13;
    if (a_tick_r) begin
      c1_r <= c0;
      c2_r <= c1_r;
    end
    tout_wl_r <= a_wl_r;
    tout_fh_r <= a_fh_r;
  end

  assign tout    = tout_r;
  assign tout_wl = tout_wl_r;
  assign tout_fh = tout_fh_r;

endmodule

FILE: sv/bce_ofifo.sv
module bce_ofifo #(
  parameter int DEPTH = 2 * bce_pkg::PASSES_DEF + 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic               drop,
  input  logic               push,
  input  bce_pkg::out_item_t push_data,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output bce_pkg::out_item_t out_data
);
  import bce_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t        fifo_q [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r, wr_nxt, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, used_r, used_nxt;
  logic             pop;

  // Pointers, fill count and credit: tokens in flight plus stored results
  always_comb begin
    pop      = (cnt_r != '0) && !out_stall;
    wr_nxt   = wr_r;
    rd_nxt   = rd_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    cnt_nxt  = cnt_r + CNT_W'(push) - CNT_W'(pop);
    used_nxt = used_r + CNT_W'(take) - CNT_W'(drop) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      cnt_r  <= '0;
      used_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      cnt_r  <= cnt_nxt;
      used_r <= used_nxt;
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_q[wr_r] <= push_data;
    end
  end

  assign in_stall  = used_r == CNT_W'(DEPTH);
  assign out_valid = cnt_r != '0;
  assign out_data  = fifo_q[rd_r];

endmodule

FILE: sv/binary_erosion_3x3_cascade_unit.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | in_data  {pixel_in, flush}
// out     | output    | out_valid/out_stall | out_data {pixel_out, frame_last}
// cfg     | input     | cfg_we              | cfg_index, cfg_data (12 bits)
//
// One item per cycle is taken while in_stall is low; each erosion pass reads
// the line buffer, then forms the column AND and writes back, and the results
// of the last pass wait in the output FIFO until out_stall is low.
// A frame takes w*h + PASSES*(w+1) items.
// Reset is synchronous; line buffers are not cleared, rows outside the frame
// are masked. in_stall rises only once 2*PASSES+3 items are in flight or wait.
module binary_erosion_3x3_cascade_unit #(
  parameter int MAX_WIDTH = bce_pkg::MAX_WIDTH_DEF,
  parameter int PASSES    = bce_pkg::PASSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bce_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bce_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [bce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bce_pkg::DIM_W-1:0]     cfg_data
);
  import bce_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DEPTH = 2 * PASSES + 3;

  tok_t             tok_s [PASSES+1];
  logic [CW-1:0]    wl_s  [PASSES+1];
  logic [DIM_W-1:0] fh_s  [PASSES+1];
  logic             take, drop, push;
  out_item_t        push_data;

  // Frame control and item intake
  bce_feed #(
    .MAX_WIDTH (MAX_WIDTH),
    .PASSES    (PASSES),
    .CW        (CW)
  ) u_feed (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tok_o     (tok_s[0]),
    .wl_o      (wl_s[0]),
    .fh_o      (fh_s[0]),
    .take_o    (take)
  );

  // Cascade of erosion passes
  for (genvar s = 0; s < PASSES; s++) begin : g_pass
    bce_stage #(
      .MAX_WIDTH (MAX_WIDTH),
      .CW        (CW)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .tin     (tok_s[s]),
      .tin_wl  (wl_s[s]),
      .tin_fh  (fh_s[s]),
      .tout    (tok_s[s+1]),
      .tout_wl (wl_s[s+1]),
      .tout_fh (fh_s[s+1])
    );
  end

  // Keep pixels of the last pass, retire tokens without one
  always_comb begin
    push                 = tok_s[PASSES].vld && tok_s[PASSES].pv;
    drop                 = tok_s[PASSES].vld && !tok_s[PASSES].pv;
    push_data.pixel_out  = tok_s[PASSES].pix;
    push_data.frame_last = tok_s[PASSES].eof;
  end

  bce_ofifo #(
    .DEPTH (DEPTH)
  ) u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .drop      (drop),
    .push      (push),
    .push_data (push_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: sv/bce_chk.sv
module bce_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bce_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input bce_pkg::out_item_t out_data
);
  import bce_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // Come out of reset empty and ready
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind binary_erosion_3x3_cascade_unit bce_chk u_bce_chk (.*);

FILE: verif/tb_binary_erosion_3x3_cascade_unit.sv
`timescale 1ns / 1ps

module tb_binary_erosion_3x3_cascade_unit;
  import bce_pkg::*;

  localparam int NPASS = PASSES_DEF;
  localparam int MAXW = MAX_WIDTH_DEF;
  localparam int HIST = 2 * MAXW + 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = 2 * NPASS + 12;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int MAX_REPORTS = 40;

  // Predicts the eroded stream and holds the pixels still owed by the block
  class erosion_tracker;
    bit hist[NPASS][HIST];
    int unsigned taken[NPASS];
    int unsigned srow[NPASS];
    int unsigned scol[NPASS];
    int unsigned out_cnt;
    logic [DIM_W-1:0] reg_w;
    logic [DIM_W-1:0] reg_h;
    int unsigned fw, fh, fn, fed;
    bit busy;
    out_item_t expected_pixels[$];
    int errors;
    int frames;
    int checked;
    int fg_seen;

    function new();
      reg_w = DIM_RESET;
      reg_h = DIM_RESET;
      fw = 1;
      fh = 1;
      fn = 1;
      fed = 0;
      busy = 1'b0;
      out_cnt = 0;
      errors = 0;
      frames = 0;
      checked = 0;
      fg_seen = 0;
    endfunction

    function void note_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      if (idx == CFG_IMAGE_WIDTH) reg_w = val;
      else if (idx == CFG_IMAGE_HEIGHT) reg_h = val;
    endfunction

    // AND of the in-frame 3x3 neighborhood seen by one stage
    function bit erode_at(int s, int r, int c);
      bit v;
      int rr, cc;
      v = 1'b1;
      for (int dr = -1; dr <= 1; dr++) begin
        rr = r + dr;
        if (rr < 0 || rr >= int'(fh)) continue;
        for (int dc = -1; dc <= 1; dc++) begin
          cc = c + dc;
          if (cc < 0 || cc >= int'(fw)) continue;
          v &= hist[s][(rr * int'(fw) + cc) % HIST];
        end
      end
      return v;
    endfunction

    function void take_item(in_item_t it);
      bit flowing, val, moved, emit, res;
      out_item_t r;
      if (!busy) begin
        // drop flush while idle; otherwise latch the frame size
        if (it.flush) return;
        fw = (reg_w == 0) ? 1 : int'(reg_w);
        if (fw > MAXW) fw = MAXW;
        fh = (reg_h == 0) ? 1 : int'(reg_h);
        fn = fw * fh;
        fed = 0;
        out_cnt = 0;
        for (int s = 0; s < NPASS; s++) begin
          taken[s] = 0;
          srow[s] = 0;
          scol[s] = 0;
        end
        busy = 1'b1;
        frames++;
      end else if (it.flush && fed < fn) begin
        return;
      end
      flowing = fed < fn;
      val = it.pixel_in;
      if (flowing) fed++;
      for (int s = 0; s < NPASS; s++) begin
        moved = 1'b0;
        emit = 1'b0;
        res = 1'b0;
        if (flowing) begin
          hist[s][taken[s] % HIST] = val;
          taken[s]++;
          moved = 1'b1;
        end else if (taken[s] >= fn) begin
          taken[s]++;
          moved = 1'b1;
        end
        if (moved && taken[s] >= fw + 2 && srow[s] < fh) begin
          res = erode_at(s, int'(srow[s]), int'(scol[s]));
          emit = 1'b1;
          scol[s]++;
          if (scol[s] >= fw) begin
            scol[s] = 0;
            srow[s]++;
          end
        end
        flowing = emit;
        val = res;
      end
      if (!flowing) return;
      out_cnt++;
      r.pixel_out = val;
      r.frame_last = (out_cnt >= fn);
      expected_pixels.push_back(r);
      if (out_cnt >= fn) busy = 1'b0;
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none actual %b", $time, got);
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (got.pixel_out) fg_seen++;
      if (got.pixel_out !== want.pixel_out) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: pixel_out mismatch, expected %b actual %b", $time,
                   want.pixel_out, got.pixel_out);
      end
      if (got.frame_last !== want.frame_last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: frame_last mismatch, expected %b actual %b", $time,
                   want.frame_last, got.frame_last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  erosion_tracker sb = new();
  bit idle_on = 1'b0;
  int n_items = 0;
  int stall_left = 0;
  int cycle_cnt = 0;

  binary_erosion_3x3_cascade_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Check accepted results and stall the result side in bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_data);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("binary_erosion_3x3_cascade_unit verification failed");
      $finish;
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_item(it);
    n_items++;
  endtask

  function automatic in_item_t make_pixel(input int fg_pct);
    in_item_t it;
    it.flush = 1'b0;
    it.pixel_in = ($urandom_range(0, 99) < fg_pct);
    return it;
  endfunction

  // Hold off the input until every owed result is out
  task automatic wait_results_out();
    in_valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Drain, then let ignored items leave the pipeline
  task automatic settle();
    wait_results_out();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.note_register(idx, val);
    cfg_we <= 1'b0;
  endtask

  // One frame: set size, stream pixels with optional noise, then drain
  task automatic run_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input int fg_pct, input bit noisy, input bit pause_mid);
    in_item_t it;
    bit paused;
    int idle_flushes;
    paused = 1'b0;
    settle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    if (noisy) begin
      write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B,
                DIM_W'($urandom_range(0, 4095)));
      idle_flushes = $urandom_range(1, 3);
      repeat (idle_flushes) begin
        it.flush = 1'b1;
        it.pixel_in = 1'($urandom_range(0, 1));
        send_item(it);
      end
    end
    send_item(make_pixel(fg_pct));
    while (sb.fed < sb.fn) begin
      if (pause_mid && !paused && sb.fed >= sb.fn / 2) begin
        wait_results_out();
        paused = 1'b1;
      end
      if (noisy && $urandom_range(0, 19) == 0) begin
        it.flush = 1'b1;
        it.pixel_in = 1'($urandom_range(0, 1));
      end else begin
        it = make_pixel(fg_pct);
      end
      send_item(it);
    end
    // tail: flush items, or pixels that count as flush
    while (sb.busy) begin
      it.flush = noisy ? 1'($urandom_range(0, 1)) : 1'b1;
      it.pixel_in = 1'($urandom_range(0, 1));
      send_item(it);
    end
  endtask

  function automatic logic [DIM_W-1:0] pick_dim(input int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return DIM_W'($urandom_range(0, 1));
    if (r == 9) return DIM_W'($urandom_range(hi + 1, 4 * hi));
    return DIM_W'($urandom_range(1, hi));
  endfunction

  initial begin
    int fg_choice[4];
    int base;
    int idx;
    fg_choice = '{50, 85, 95, 100};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: width and height zero, spare indexes, small solid frame
    write_reg(CFG_SPARE_A, 12'hfff);
    write_reg(CFG_SPARE_B, 12'h000);
    run_frame(12'd0, 12'd0, 100, 1'b1, 1'b0);
    run_frame(12'd3, 12'd2, 100, 1'b0, 1'b0);

    // Random frames, mostly small, with idling switched per frame
    base = n_items;
    idx = 0;
    while (n_items - base < 2000) begin
      idle_on = ($urandom_range(0, 3) != 0);
      run_frame(pick_dim(12), pick_dim(10), fg_choice[$urandom_range(0, 3)],
                ($urandom_range(0, 2) != 0), (idx % 5 == 2));
      idx++;
    end

    // Closing stretch at full rate
    idle_on = 1'b0;
    repeat (3) run_frame(pick_dim(12), pick_dim(10), 95, 1'b1, 1'b0);

    settle();
    $display("Covered %0d frames with %0d input items;", sb.frames, n_items);
    $display("%0d result pixels checked, %0d foreground.", sb.checked, sb.fg_seen);
    if (sb.errors == 0) begin
      $display("binary_erosion_3x3_cascade_unit verification clean");
    end else begin
      $display("binary_erosion_3x3_cascade_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/bce_pkg.sv
sv/bce_feed.sv
sv/bce_stage.sv
sv/bce_ofifo.sv
sv/binary_erosion_3x3_cascade_unit.sv
sv/bce_chk.sv
verif/tb_binary_erosion_3x3_cascade_unit.sv
